@@ rtl/core/mtrs_pkg.sv @@
// ============================================================================
// mtrs_pkg
// Shared types and constants of the Modbus TCP register server core.
// ============================================================================
package mtrs_pkg;

   // Default sizes
   localparam int REG_COUNT_DEF      = 128;
   localparam int FRAME_BYTES_DEF    = 256;
   localparam int MAX_READ_WORDS_DEF = 27;

   // Frame byte count width, holds frame totals up to 1023 bytes
   localparam int TOTAL_W   = 10;
   // Frame header bytes kept in flops (transaction id .. quantity)
   localparam int HDR_BYTES = 12;

   // Response constants
   localparam logic [7:0] BYTE_ZERO      = 8'h00;
   localparam logic [7:0] WRITE_LEN_LOW  = 8'h06;
   localparam logic [7:0] READ_LEN_BASE  = 8'h03;
   localparam logic [5:0] WRITE_RESP_LEN = 6'd12;
   localparam int         READ_HDR_LEN   = 9;
   localparam int         WR_DATA_BASE   = 13;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_UNIT_ID  = 2'd0,
      CSR_WRITE_FC = 2'd1,
      CSR_READ_FC  = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   // One served frame, handed from front to back
   typedef struct packed {
      op_type             op;
      logic [7:0]         tid_hi;
      logic [7:0]         tid_lo;
      logic [15:0]        start;
      logic [15:0]        qty;
      logic [TOTAL_W-1:0] total;
   } cmd_type;

   // Header byte update from the response path
   typedef struct packed {
      logic       we;
      logic [3:0] idx;
      logic [7:0] data;
   } hdr_wr_type;

   typedef struct packed {
      logic init_done;
      logic done;
   } back_status_type;

endpackage

@@ rtl/core/modbus_tcp_register_server_core.sv @@
// ============================================================================
// modbus_tcp_register_server_core
// Modbus TCP holding register server: frame receive, register file, response.
// ============================================================================
// Usage:
//   req_* carries received TCP words, one byte per word, valid/ready.
//   rsp_* carries response words; rsp_last_byte marks the end of a response.
//   csr_* writes unit id, write function code and read function code; write
//   only while no frame is in progress and no response is pending.
// Throughput and sequence:
//   A frame byte is taken every cycle. On the byte that completes a served
//   frame, req_ready drops until the last response word is loaded into the
//   output register. A write takes a dispatch step, two frame buffer reads
//   and one register file write per stored word, then 12 response words;
//   a read takes a dispatch step, 9 header words, then one register file
//   read and two output words per word. A frame that is not served costs
//   nothing extra.
// Reset:
//   The register file is cleared one entry per cycle, with req_ready low;
//   configuration writes are taken during that pass.
// Stall:
//   A held rsp_ready stalls the response sequencer; the next frame is taken
//   as soon as its final word sits in the output register.
// ============================================================================
module modbus_tcp_register_server_core #(
   parameter int REG_COUNT      = mtrs_pkg::REG_COUNT_DEF,
   parameter int FRAME_BYTES    = mtrs_pkg::FRAME_BYTES_DEF,
   parameter int MAX_READ_WORDS = mtrs_pkg::MAX_READ_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last_byte,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int FAW = $clog2(FRAME_BYTES);

   logic [7:0] unit_id_ff, unit_id_in;
   logic [7:0] write_fc_ff, write_fc_in;
   logic [7:0] read_fc_ff, read_fc_in;

   logic                      fram_we;
   logic [FAW-1:0]            fram_waddr, fram_raddr;
   logic [7:0]                fram_wdata, fram_rdata;
   logic                      push, pop, q_valid, q_full;
   mtrs_pkg::cmd_type         push_cmd, q_head;
   mtrs_pkg::back_status_type back_status;
   mtrs_pkg::hdr_wr_type      hdr_wr;

   // Configuration registers
   always_comb begin
      unit_id_in  = unit_id_ff;
      write_fc_in = write_fc_ff;
      read_fc_in  = read_fc_ff;
      if (csr_we) begin
         unique case (mtrs_pkg::csr_index_type'(csr_index))
            mtrs_pkg::CSR_UNIT_ID:  unit_id_in  = csr_wdata;
            mtrs_pkg::CSR_WRITE_FC: write_fc_in = csr_wdata;
            mtrs_pkg::CSR_READ_FC:  read_fc_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_id_ff  <= 8'd1;
         write_fc_ff <= 8'd16;
         read_fc_ff  <= 8'd3;
      end else begin
         unit_id_ff  <= unit_id_in;
         write_fc_ff <= write_fc_in;
         read_fc_ff  <= read_fc_in;
      end
   end

   // Frame buffer
   mtrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
      .clock (clock),
      .we    (fram_we),
      .waddr (fram_waddr),
      .wdata (fram_wdata),
      .raddr (fram_raddr),
      .rdata (fram_rdata)
   );

   mtrs_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .unit_id     (unit_id_ff),
      .write_fc    (write_fc_ff),
      .read_fc     (read_fc_ff),
      .back_status (back_status),
      .hdr_wr      (hdr_wr),
      .fram_we     (fram_we),
      .fram_waddr  (fram_waddr),
      .fram_wdata  (fram_wdata),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   mtrs_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .valid    (q_valid),
      .full     (q_full),
      .head     (q_head)
   );

   mtrs_back #(
      .REG_COUNT      (REG_COUNT),
      .FRAME_BYTES    (FRAME_BYTES),
      .MAX_READ_WORDS (MAX_READ_WORDS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (q_head),
      .q_pop         (pop),
      .unit_id       (unit_id_ff),
      .write_fc      (write_fc_ff),
      .read_fc       (read_fc_ff),
      .fram_raddr    (fram_raddr),
      .fram_rdata    (fram_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte),
      .back_status   (back_status),
      .hdr_wr        (hdr_wr)
   );

   // Checks
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("command pushed into full queue");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      !back_status.init_done |-> !req_ready)
      else $error("word accepted during register clear");

   a_hdr_vs_accept: assert property (@(posedge clock) disable iff (reset)
      hdr_wr.we |-> !(req_valid && req_ready))
      else $error("header update collides with received word");

   a_done_idle_queue: assert property (@(posedge clock) disable iff (reset)
      back_status.done |-> !q_valid)
      else $error("response finished with a command still queued");

endmodule

@@ rtl/core/mtrs_ram.sv @@
// ============================================================================
// mtrs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module mtrs_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/mtrs_cmd_queue.sv @@
// ============================================================================
// mtrs_cmd_queue
// Two-entry queue of served frame commands between front and back.
// ============================================================================
module mtrs_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mtrs_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              valid,
   output logic              full,
   output mtrs_pkg::cmd_type head
);

   mtrs_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   // Drop a push into a full queue, a pop from an empty one
   always_comb begin
      do_push   = push && (count_ff != 2'd2);
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign valid = (count_ff != 2'd0);
   assign full  = (count_ff == 2'd2);
   assign head  = slot_ff[rd_ptr_ff];

endmodule

@@ rtl/core/mtrs_front.sv @@
// ============================================================================
// mtrs_front
// Receive side: stores bytes, tracks the header, detects complete frames
// and classifies them into write or read commands.
// ============================================================================
module mtrs_front #(
   parameter int FRAME_BYTES = mtrs_pkg::FRAME_BYTES_DEF,
   localparam int FAW        = $clog2(FRAME_BYTES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   input  logic [7:0]                    unit_id,
   input  logic [7:0]                    write_fc,
   input  logic [7:0]                    read_fc,
   input  mtrs_pkg::back_status_type     back_status,
   input  mtrs_pkg::hdr_wr_type          hdr_wr,
   output logic                          fram_we,
   output logic [FAW-1:0]                fram_waddr,
   output logic [7:0]                    fram_wdata,
   output logic                          push,
   output mtrs_pkg::cmd_type             push_cmd
);

   localparam int CNT_W = $clog2(FRAME_BYTES + 1);
   localparam int TW    = mtrs_pkg::TOTAL_W;
   localparam int HB    = mtrs_pkg::HDR_BYTES;

   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] pos_eff, total;
   logic [TW-1:0]    total_w;
   logic             busy_ff, busy_in;
   logic [7:0]       hdr_ff [HB];
   logic [7:0]       hdr_in [HB];
   logic [7:0]       view   [HB];
   logic             accept, complete, served;

   assign req_ready = !busy_ff && back_status.init_done;
   assign accept    = req_valid && req_ready;

   // Frame position, header view with the incoming word, completion test
   always_comb begin
      pos_eff = (pos_ff >= CNT_W'(FRAME_BYTES)) ? '0 : pos_ff;
      total   = pos_eff + 1'b1;
      total_w = TW'(total);
      for (int i = 0; i < HB; i++) begin
         view[i] = (pos_eff == CNT_W'(i)) ? req_rx_byte : hdr_ff[i];
      end
      complete = (total_w >= TW'(7)) && (TW'(view[5]) == total_w - TW'(6));
      served   = complete && (view[6] == unit_id) &&
                 ((view[7] == write_fc) || (view[7] == read_fc));
   end

   // Build the command
   always_comb begin
      push            = accept && served;
      push_cmd.op     = (view[7] == write_fc) ? mtrs_pkg::OP_WRITE : mtrs_pkg::OP_READ;
      push_cmd.tid_hi = view[0];
      push_cmd.tid_lo = view[1];
      push_cmd.start  = {view[8], view[9]};
      push_cmd.qty    = {view[10], view[11]};
      push_cmd.total  = total_w;
   end

   // Store the word in the frame buffer
   assign fram_we    = accept;
   assign fram_waddr = pos_eff[FAW-1:0];
   assign fram_wdata = req_rx_byte;

   // Next state: position, busy flag, header bytes
   always_comb begin
      pos_in  = pos_ff;
      busy_in = busy_ff;
      for (int i = 0; i < HB; i++) begin
         hdr_in[i] = hdr_ff[i];
      end
      if (accept) begin
         pos_in = complete ? '0 : total;
         for (int i = 0; i < HB; i++) begin
            hdr_in[i] = view[i];
         end
      end
      if (push) begin
         busy_in = 1'b1;
      end else if (back_status.done) begin
         busy_in = 1'b0;
      end
      if (hdr_wr.we) begin
         for (int i = 0; i < HB; i++) begin
            if (hdr_wr.idx == 4'(i)) begin
               hdr_in[i] = hdr_wr.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HB; i++) begin
         hdr_ff[i] <= hdr_in[i];
      end
   end

endmodule

@@ rtl/core/mtrs_back.sv @@
// ============================================================================
// mtrs_back
// Execute side: clears the register file after reset, performs register
// writes and reads, and streams the response words.
// ============================================================================
module mtrs_back #(
   parameter int REG_COUNT      = mtrs_pkg::REG_COUNT_DEF,
   parameter int FRAME_BYTES    = mtrs_pkg::FRAME_BYTES_DEF,
   parameter int MAX_READ_WORDS = mtrs_pkg::MAX_READ_WORDS_DEF,
   localparam int FAW           = $clog2(FRAME_BYTES)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  mtrs_pkg::cmd_type         q_cmd,
   output logic                      q_pop,
   input  logic [7:0]                unit_id,
   input  logic [7:0]                write_fc,
   input  logic [7:0]                read_fc,
   output logic [FAW-1:0]            fram_raddr,
   input  logic [7:0]                fram_rdata,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_tx_byte,
   output logic                      rsp_last_byte,
   output mtrs_pkg::back_status_type back_status,
   output mtrs_pkg::hdr_wr_type      hdr_wr
);

   localparam int RAW = $clog2(REG_COUNT);
   localparam int TW  = mtrs_pkg::TOTAL_W;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_W_HI  = 7'b0000100,
      ST_W_LO  = 7'b0001000,
      ST_W_WR  = 7'b0010000,
      ST_FETCH = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   mtrs_pkg::cmd_type cmd_ff, cmd_in;
   logic [8:0]        n_ff, n_in;
   logic [8:0]        i_ff, i_in;
   logic [5:0]        k_ff, k_in;
   logic [5:0]        len_ff, len_in;
   logic [7:0]        hi_ff, hi_in;
   logic [RAW-1:0]    clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        tx_ff, tx_in;
   logic              last_ff, last_in;

   logic [TW-1:0]     avail;
   logic [15:0]       qty_cap;
   logic [8:0]        n_pop;
   logic [16:0]       wa17, ra17;
   logic [5:0]        word_j;
   logic              wa_ok, ra_ok;
   logic              reg_we;
   logic [RAW-1:0]    reg_waddr;
   logic [15:0]       reg_wdata, reg_rdata;
   logic [TW-1:0]     fa;
   logic [7:0]        byte_val, data_byte, n2;
   logic              is_write, slot_free, load, last;

   // Register file
   mtrs_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_regs (
      .clock (clock),
      .we    (reg_we),
      .waddr (reg_waddr),
      .wdata (reg_wdata),
      .raddr (ra17[RAW-1:0]),
      .rdata (reg_rdata)
   );

   // Word count for the command at the queue head
   always_comb begin
      avail   = (q_cmd.total >= TW'(15)) ? ((q_cmd.total - TW'(13)) >> 1) : '0;
      qty_cap = 16'(MAX_READ_WORDS);
      if (q_cmd.op == mtrs_pkg::OP_WRITE) begin
         n_pop = (q_cmd.qty < 16'(avail)) ? 9'(q_cmd.qty) : 9'(avail);
      end else begin
         n_pop = (q_cmd.qty > qty_cap) ? 9'(qty_cap) : 9'(q_cmd.qty);
      end
   end

   // Addresses into the register file and the frame buffer
   always_comb begin
      is_write = (cmd_ff.op == mtrs_pkg::OP_WRITE);
      wa17     = {1'b0, cmd_ff.start} + 17'(i_ff);
      word_j   = (k_ff - 6'd9) >> 1;
      ra17     = {1'b0, cmd_ff.start} + 17'(word_j);
      wa_ok    = (wa17 < 17'(REG_COUNT));
      ra_ok    = (ra17 < 17'(REG_COUNT));
      fa       = TW'(mtrs_pkg::WR_DATA_BASE) + TW'({i_ff, 1'b0}) +
                 TW'(state_ff == ST_W_LO);
      fram_raddr = fa[FAW-1:0];
   end

   // Register file write port: clearing pass or register write
   always_comb begin
      reg_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_W_WR) && wa_ok);
      reg_waddr = (state_ff == ST_CLEAR) ? clr_ff : wa17[RAW-1:0];
      reg_wdata = (state_ff == ST_CLEAR) ? 16'h0000 : {hi_ff, fram_rdata};
   end

   // Response word for position k
   always_comb begin
      n2        = 8'({n_ff, 1'b0});
      data_byte = !ra_ok ? mtrs_pkg::BYTE_ZERO :
                  (k_ff[0] ? reg_rdata[15:8] : reg_rdata[7:0]);
      case (k_ff) inside
         6'd0:             byte_val = cmd_ff.tid_hi;
         6'd1:             byte_val = cmd_ff.tid_lo;
         6'd2, 6'd3, 6'd4: byte_val = mtrs_pkg::BYTE_ZERO;
         6'd5:             byte_val = is_write ? mtrs_pkg::WRITE_LEN_LOW :
                                      mtrs_pkg::READ_LEN_BASE + n2;
         6'd6:             byte_val = unit_id;
         6'd7:             byte_val = is_write ? write_fc : read_fc;
         6'd8:             byte_val = is_write ? cmd_ff.start[15:8] : n2;
         6'd9:             byte_val = is_write ? cmd_ff.start[7:0] : data_byte;
         6'd10:            byte_val = is_write ? cmd_ff.qty[15:8] : data_byte;
         6'd11:            byte_val = is_write ? cmd_ff.qty[7:0] : data_byte;
         default:          byte_val = data_byte;
      endcase
   end

   // Output register handshake
   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      load      = (state_ff == ST_EMIT) && slot_free;
      last      = (k_ff == len_ff - 6'd1);
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      len_in       = len_ff;
      hi_in        = hi_ff;
      clr_in       = clr_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tx_in        = tx_ff;
      last_in      = last_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == RAW'(REG_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               n_in   = n_pop;
               i_in   = '0;
               k_in   = '0;
               len_in = (q_cmd.op == mtrs_pkg::OP_WRITE) ? mtrs_pkg::WRITE_RESP_LEN :
                        6'(mtrs_pkg::READ_HDR_LEN) + 6'({n_pop, 1'b0});
               state_in = ((q_cmd.op == mtrs_pkg::OP_WRITE) && (n_pop != 9'd0)) ?
                          ST_W_HI : ST_EMIT;
            end
         end
         ST_W_HI: begin
            state_in = ST_W_LO;
         end
         ST_W_LO: begin
            hi_in    = fram_rdata;
            state_in = ST_W_WR;
         end
         ST_W_WR: begin
            i_in     = i_ff + 1'b1;
            state_in = (i_ff + 9'd1 == n_ff) ? ST_EMIT : ST_W_HI;
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               tx_in        = byte_val;
               last_in      = last;
               k_in         = k_ff + 1'b1;
               if (last) begin
                  state_in = ST_IDLE;
               end else if (!is_write && (k_ff >= 6'd8) && !k_ff[0]) begin
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      n_ff    <= n_in;
      i_ff    <= i_in;
      k_ff    <= k_in;
      len_ff  <= len_in;
      hi_ff   <= hi_in;
      tx_ff   <= tx_in;
      last_ff <= last_in;
   end

   // Mirror response words into the header flops of the front
   always_comb begin
      hdr_wr.we   = load && (k_ff < 6'(mtrs_pkg::HDR_BYTES));
      hdr_wr.idx  = k_ff[3:0];
      hdr_wr.data = byte_val;
   end

   assign back_status.init_done = (state_ff != ST_CLEAR);
   assign back_status.done      = load && last;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = tx_ff;
   assign rsp_last_byte = last_ff;

endmodule

@@ dv/modbus_tcp_register_server_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_tcp_register_server_core_tb
// Streams Modbus TCP request bytes into the core and checks every response
// word against a byte-level model of the frame buffer and register file.
// ----------------------------------------------------------------------------
module modbus_tcp_register_server_core_tb;

   localparam int NREG      = 128;
   localparam int NFRAME    = 256;
   localparam int READ_CLIP = 27;
   localparam int CYCLE_CAP = 400000;

   typedef struct packed {
      logic [7:0] tx;
      logic       last;
   } tx_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_last_byte;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [7:0] csr_wdata = 8'h00;

   // Model state
   logic [7:0]  frame_buf [NFRAME];
   logic [15:0] hold_regs [NREG];
   int          frame_fill;
   logic [7:0]  cur_unit, cur_wr_fc, cur_rd_fc;
   tx_word_type tx_word_q [$];

   int snd_idle, rcv_idle, hold_left;
   int fails, words_checked, bytes_sent, cycles;

   modbus_tcp_register_server_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_tx_byte(rsp_tx_byte), .rsp_last_byte(rsp_last_byte),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advance the model by one received byte, queue any response words
   function automatic void serve_rx_byte(input logic [7:0] b);
      logic [7:0] resp [0:66];
      int total, n, avail, rlen;
      logic [15:0] start, qty, w;
      logic [7:0] func;
      if (frame_fill >= NFRAME) frame_fill = 0;
      frame_buf[frame_fill] = b;
      frame_fill++;
      total = frame_fill;
      if (total < 6 || frame_buf[5] == 8'h00 || int'(frame_buf[5]) != total - 6) return;
      frame_fill = 0;
      if (frame_buf[6] != cur_unit) return;
      func  = frame_buf[7];
      start = {frame_buf[8], frame_buf[9]};
      qty   = {frame_buf[10], frame_buf[11]};
      resp[0] = frame_buf[0];
      resp[1] = frame_buf[1];
      resp[2] = mtrs_pkg::BYTE_ZERO;
      resp[3] = mtrs_pkg::BYTE_ZERO;
      resp[4] = mtrs_pkg::BYTE_ZERO;
      resp[6] = cur_unit;
      if (func == cur_wr_fc) begin
         avail = (total >= 15) ? (total - 13) / 2 : 0;
         n = (int'(qty) < avail) ? int'(qty) : avail;
         for (int i = 0; i < n; i++) begin
            w = {frame_buf[13 + 2 * i], frame_buf[14 + 2 * i]};
            if (int'(start) + i < NREG) hold_regs[int'(start) + i] = w;
         end
         resp[5]  = mtrs_pkg::WRITE_LEN_LOW;
         resp[7]  = cur_wr_fc;
         resp[8]  = start[15:8];
         resp[9]  = start[7:0];
         resp[10] = qty[15:8];
         resp[11] = qty[7:0];
         rlen = 12;
      end else if (func == cur_rd_fc) begin
         n = (int'(qty) > READ_CLIP) ? READ_CLIP : int'(qty);
         resp[5] = 8'(3 + 2 * n);
         resp[7] = cur_rd_fc;
         resp[8] = 8'(2 * n);
         for (int i = 0; i < n; i++) begin
            w = (int'(start) + i < NREG) ? hold_regs[int'(start) + i] : 16'h0000;
            resp[9 + 2 * i]  = w[15:8];
            resp[10 + 2 * i] = w[7:0];
         end
         rlen = 9 + 2 * n;
      end else begin
         return;
      end
      for (int k = 0; k < rlen; k++) begin
         frame_buf[k] = resp[k];
         tx_word_q.push_back('{tx: resp[k], last: (k == rlen - 1)});
      end
   endfunction

   // Offer one word, hold it until accepted
   task automatic send_byte(input logic [7:0] b);
      forever begin
         @(negedge clock);
         if ($urandom_range(99) < snd_idle) req_valid <= 1'b0;
         else break;
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      serve_rx_byte(b);
      bytes_sent++;
   endtask

   // Build one request; ndata bytes follow the byte-count byte (none: 12-byte frame)
   task automatic send_frame(input logic [7:0] unit, input logic [7:0] func,
                             input logic [15:0] start, input logic [15:0] qty,
                             input int ndata);
      logic [7:0] len5;
      len5 = (ndata == 0) ? 8'd6 : 8'(7 + ndata);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      send_byte(len5);
      send_byte(unit);
      send_byte(func);
      send_byte(start[15:8]);
      send_byte(start[7:0]);
      send_byte(qty[15:8]);
      send_byte(qty[7:0]);
      if (ndata > 0) begin
         send_byte(8'(ndata));
         for (int i = 0; i < ndata; i++) send_byte(8'($urandom));
      end
   endtask

   // Bring the frame counter back to zero after noise
   task automatic realign_frame();
      while (frame_fill != 0) begin
         if (frame_fill == 5) send_byte(8'd1);
         else if (frame_fill == 6) send_byte(cur_unit + 8'd1);
         else send_byte(8'($urandom));
      end
   endtask

   task automatic write_csr(input mtrs_pkg::csr_index_type idx, input logic [7:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         mtrs_pkg::CSR_UNIT_ID:  cur_unit  = v;
         mtrs_pkg::CSR_WRITE_FC: cur_wr_fc = v;
         default:                cur_rd_fc = v;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Drop the offer, drain all responses and let the core go quiet
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (tx_word_q.size() == 0);
      repeat (40) @(negedge clock);
   endtask

   // Receiver: long hold-off when asked, else random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   // Compare each accepted response word with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (tx_word_q.size() == 0) begin
            $display("%0t: unexpected word tx=%02h last=%0b", $time, rsp_tx_byte,
                     rsp_last_byte);
            fails++;
         end else begin
            if (rsp_tx_byte !== tx_word_q[0].tx || rsp_last_byte !== tx_word_q[0].last) begin
               $display("%0t: mismatch expected tx=%02h last=%0b actual tx=%02h last=%0b",
                        $time, tx_word_q[0].tx, tx_word_q[0].last, rsp_tx_byte,
                        rsp_last_byte);
               fails++;
            end
            void'(tx_word_q.pop_front());
            words_checked++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d words pending", cycles, tx_word_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_defaults();
      // Full-length first frame so every header byte is defined
      send_frame(8'd1, 8'd16, 16'd0, 16'd3, 6);
      send_frame(8'd1, 8'd3, 16'd0, 16'd4, 0);
   endtask

   task automatic test_edges();
      send_frame(cur_unit, cur_wr_fc, 16'd127, 16'd2, 4);       // top register, one dropped
      send_frame(cur_unit, cur_rd_fc, 16'd126, 16'd4, 0);       // reads past the end as zero
      send_frame(cur_unit, cur_wr_fc, 16'hFFFF, 16'd1, 2);      // out of range write
      send_frame(cur_unit, cur_rd_fc, 16'd0, 16'hFFFF, 0);      // quantity clipped
      send_frame(cur_unit, cur_rd_fc, 16'd0, 16'd0, 0);         // empty read
      send_frame(cur_unit, cur_wr_fc, 16'd10, 16'd5, 3);        // short write frame
      send_frame(cur_unit, cur_wr_fc, 16'd20, 16'd0, 4);        // zero quantity write
      send_frame(cur_unit + 8'd1, cur_rd_fc, 16'd0, 16'd2, 0);  // unit mismatch
      send_frame(cur_unit, 8'hFF, 16'd0, 16'd2, 0);             // unknown function
      send_frame(cur_unit, cur_rd_fc, 16'd10, 16'd6, 0);
   endtask

   task automatic test_config();
      wait_idle();
      write_csr(mtrs_pkg::CSR_UNIT_ID, 8'h00);
      write_csr(mtrs_pkg::CSR_WRITE_FC, 8'hFF);
      write_csr(mtrs_pkg::CSR_READ_FC, 8'h00);
      send_frame(8'h00, 8'hFF, 16'd5, 16'd2, 4);
      send_frame(8'h00, 8'h00, 16'd4, 16'd4, 0);
      wait_idle();
      write_csr(mtrs_pkg::CSR_UNIT_ID, 8'hFF);
      write_csr(mtrs_pkg::CSR_READ_FC, 8'hFF);                  // equal codes: write wins
      send_frame(8'hFF, 8'hFF, 16'd30, 16'd1, 2);
      wait_idle();
      write_csr(mtrs_pkg::CSR_UNIT_ID, 8'h01);
      write_csr(mtrs_pkg::CSR_WRITE_FC, 8'h10);
      write_csr(mtrs_pkg::CSR_READ_FC, 8'h03);
   endtask

   task automatic random_frame();
      int pick, nw;
      logic [15:0] start;
      pick  = $urandom_range(99);
      start = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 135));
      if (pick < 45) begin
         nw = $urandom_range(1, 5);
         send_frame(cur_unit, cur_wr_fc, start,
                    ($urandom_range(3) == 0) ? 16'($urandom_range(0, 8)) : 16'(nw),
                    ($urandom_range(5) == 0) ? 2 * nw - 1 : 2 * nw);
      end else if (pick < 85) begin
         send_frame(cur_unit, cur_rd_fc, start,
                    ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)), 0);
      end else if (pick < 92) begin
         send_frame(8'($urandom), 8'($urandom), start, 16'($urandom_range(0, 4)), 0);
      end else begin
         for (int i = $urandom_range(1, 4); i > 0; i--) send_byte(8'($urandom));
         realign_frame();
      end
   endtask

   task automatic test_random(input int nbytes);
      int stop_at;
      stop_at = bytes_sent + nbytes;
      while (bytes_sent < stop_at) random_frame();
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_left = 400;
      for (int i = 0; i < 2; i++) send_frame(cur_unit, cur_rd_fc, 16'(i * 8), 16'd10, 0);
      send_byte(8'h00);                                         // then a pause until drained
      realign_frame();
      wait_idle();
   endtask

   initial begin
      for (int i = 0; i < NFRAME; i++) frame_buf[i] = 8'h00;
      for (int i = 0; i < NREG; i++) hold_regs[i] = 16'h0000;
      frame_fill = 0;
      cur_unit = 8'd1; cur_wr_fc = 8'd16; cur_rd_fc = 8'd3;
      snd_idle = 0; rcv_idle = 0; hold_left = 0;
      fails = 0; words_checked = 0; bytes_sent = 0; cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender sparse, receiver sparser
      snd_idle = 35; rcv_idle = 57;
      test_defaults();
      test_edges();
      // Roles swapped
      snd_idle = 57; rcv_idle = 35;
      test_config();
      test_random(16);
      // Full speed on both sides
      snd_idle = 0; rcv_idle = 0;
      test_random(16);
      test_backpressure();

      wait (tx_word_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("sent %0d request bytes, checked %0d response words", bytes_sent, words_checked);
      $display("covered writes, reads, clipping, address edges, config extremes and stalls");
      if (fails == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/mtrs_pkg.sv
rtl/core/mtrs_ram.sv
rtl/core/mtrs_cmd_queue.sv
rtl/core/mtrs_front.sv
rtl/core/mtrs_back.sv
rtl/core/modbus_tcp_register_server_core.sv
dv/modbus_tcp_register_server_core_tb.sv
